// ===== hdl/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, register indexes and helpers for the environmental sensor
// compensation pipeline.
// ----------------------------------------------------------------------------
package esc_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_TEMP    = 3'd0;
  localparam logic [2:0] REG_PRESS_A = 3'd1;
  localparam logic [2:0] REG_PRESS_B = 3'd2;
  localparam logic [2:0] REG_MIXED   = 3'd3;
  localparam logic [2:0] REG_HUMID   = 3'd4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned FRONT_LAT  = 14;
  localparam int unsigned DIV_LAT    = 32;

  localparam logic [31:0] HUM_MAX    = 32'd419430400;

  // Decoded calibration words, each extended to 32 bits.
  typedef struct packed {
    logic [31:0] t1, t2, t3;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
  } cal_t;

  // Finished fields that ride along with the pressure division.
  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] fine;
    logic [16:0] hum;
    logic        dz;
    logic        mode;
  } side_t;

  // Working fields of the front pipeline.
  typedef struct packed {
    logic [19:0] adc_t;
    logic [19:0] adc_p;
    logic [15:0] adc_h;
    logic [31:0] ta, dd, fa, b1, fine, temp, pa, ha;
    logic [31:0] d, ap5, p2a, h5a, ah6, ah3;
    logic [31:0] pb, c3, hb, x1, x2;
    logic [31:0] b2, a1, hx;
    logic [31:0] pa2, hd, nb;
    logic [31:0] den, q0, hd2;
    logic [31:0] num, hd3, ha2, sq, m;
    logic        mode;
    logic        dz;
    logic [16:0] hum;
  } front_t;

  // Arithmetic shift right of a 32-bit two's complement word.
  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    asr = 32'($signed(x) >>> n);
  endfunction

endpackage

// ===== hdl/esc_front.sv =====
// ----------------------------------------------------------------------------
// esc_front
// Fourteen-stage pipeline: temperature, fine temperature, humidity and the
// pressure terms up to the numerator and divisor of the pressure division.
// ----------------------------------------------------------------------------
module esc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_v,
  input  logic [19:0]         adc_t,
  input  logic [19:0]         adc_p,
  input  logic [15:0]         adc_h,
  input  esc_pkg::cal_t       cal,
  output logic                out_v,
  output logic [31:0]         num,
  output logic [31:0]         den,
  output esc_pkg::side_t      side
);

  esc_pkg::front_t st_r   [1:esc_pkg::FRONT_LAT];
  esc_pkg::front_t st_nxt [1:esc_pkg::FRONT_LAT];
  logic [esc_pkg::FRONT_LAT:1] v_r;

  // Stage logic: stage 1 reads the inputs, later stages the previous register.
  always_comb begin
    logic [31:0] dt;
    logic [31:0] hh;
    st_nxt[1] = st_r[1];
    st_nxt[1].adc_t = adc_t;
    st_nxt[1].adc_p = adc_p;
    st_nxt[1].adc_h = adc_h;
    st_nxt[1].ta = ((32'(adc_t) >> 3) - (cal.t1 << 1)) * cal.t2;
    dt = (32'(adc_t) >> 4) - cal.t1;
    st_nxt[1].dd = dt * dt;

    st_nxt[2] = st_r[1];
    st_nxt[2].fa = esc_pkg::asr(st_r[1].ta, 11);
    st_nxt[2].b1 = esc_pkg::asr(st_r[1].dd, 12) * cal.t3;

    st_nxt[3] = st_r[2];
    st_nxt[3].fine = st_r[2].fa + esc_pkg::asr(st_r[2].b1, 14);

    st_nxt[4] = st_r[3];
    st_nxt[4].temp = esc_pkg::asr(st_r[3].fine * 32'd5 + 32'd128, 8);
    st_nxt[4].pa = esc_pkg::asr(st_r[3].fine, 1) - 32'd64000;
    st_nxt[4].ha = st_r[3].fine - 32'd76800;

    st_nxt[5] = st_r[4];
    st_nxt[5].d = esc_pkg::asr(st_r[4].pa, 2) * esc_pkg::asr(st_r[4].pa, 2);
    st_nxt[5].ap5 = st_r[4].pa * cal.p5;
    st_nxt[5].p2a = cal.p2 * st_r[4].pa;
    st_nxt[5].h5a = cal.h5 * st_r[4].ha;
    st_nxt[5].ah6 = st_r[4].ha * cal.h6;
    st_nxt[5].ah3 = st_r[4].ha * cal.h3;

    st_nxt[6] = st_r[5];
    st_nxt[6].pb = esc_pkg::asr(st_r[5].d, 11) * cal.p6;
    st_nxt[6].c3 = cal.p3 * esc_pkg::asr(st_r[5].d, 13);
    st_nxt[6].hb = esc_pkg::asr(((32'(st_r[5].adc_h) << 14) - (cal.h4 << 20)
                                 - st_r[5].h5a) + 32'd16384, 15);
    st_nxt[6].x1 = esc_pkg::asr(st_r[5].ah6, 10);
    st_nxt[6].x2 = esc_pkg::asr(st_r[5].ah3, 11) + 32'd32768;

    st_nxt[7] = st_r[6];
    st_nxt[7].b2 = esc_pkg::asr(st_r[6].pb + (st_r[6].ap5 << 1), 2) + (cal.p4 << 16);
    st_nxt[7].a1 = esc_pkg::asr(esc_pkg::asr(st_r[6].c3, 3)
                                + esc_pkg::asr(st_r[6].p2a, 1), 18);
    st_nxt[7].hx = st_r[6].x1 * st_r[6].x2;

    st_nxt[8] = st_r[7];
    st_nxt[8].pa2 = (32'd32768 + st_r[7].a1) * cal.p1;
    st_nxt[8].hd = esc_pkg::asr(st_r[7].hx, 10) + 32'd2097152;
    st_nxt[8].nb = (32'd1048576 - 32'(st_r[7].adc_p)) - esc_pkg::asr(st_r[7].b2, 12);

    st_nxt[9] = st_r[8];
    st_nxt[9].den = esc_pkg::asr(st_r[8].pa2, 15);
    st_nxt[9].q0 = st_r[8].nb * 32'd3125;
    st_nxt[9].hd2 = st_r[8].hd * cal.h2;

    // A numerator with its top bit set is divided first and doubled after.
    st_nxt[10] = st_r[9];
    st_nxt[10].mode = st_r[9].q0[31];
    st_nxt[10].num = st_r[9].q0[31] ? st_r[9].q0 : (st_r[9].q0 << 1);
    st_nxt[10].dz = (st_r[9].den == 32'd0);
    st_nxt[10].hd3 = esc_pkg::asr(st_r[9].hd2 + 32'd8192, 14);

    st_nxt[11] = st_r[10];
    st_nxt[11].ha2 = st_r[10].hb * st_r[10].hd3;

    st_nxt[12] = st_r[11];
    st_nxt[12].sq = esc_pkg::asr(st_r[11].ha2, 15) * esc_pkg::asr(st_r[11].ha2, 15);

    st_nxt[13] = st_r[12];
    st_nxt[13].m = esc_pkg::asr(st_r[12].sq, 7) * cal.h1;

    // Humidity clamp to the valid range before the final scaling.
    st_nxt[14] = st_r[13];
    hh = st_r[13].ha2 - esc_pkg::asr(st_r[13].m, 4);
    if (hh[31]) begin
      hh = 32'd0;
    end
    if (hh > esc_pkg::HUM_MAX) begin
      hh = esc_pkg::HUM_MAX;
    end
    st_nxt[14].hum = hh[28:12];
  end

  // Stage registers advance together while the pipeline is enabled.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k <= esc_pkg::FRONT_LAT; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[esc_pkg::FRONT_LAT-1:1], in_v};
    end
  end

  assign out_v     = v_r[esc_pkg::FRONT_LAT];
  assign num       = st_r[esc_pkg::FRONT_LAT].num;
  assign den       = st_r[esc_pkg::FRONT_LAT].den;
  assign side.temp = st_r[esc_pkg::FRONT_LAT].temp;
  assign side.fine = st_r[esc_pkg::FRONT_LAT].fine;
  assign side.hum  = st_r[esc_pkg::FRONT_LAT].hum;
  assign side.dz   = st_r[esc_pkg::FRONT_LAT].dz;
  assign side.mode = st_r[esc_pkg::FRONT_LAT].mode;

endmodule

// ===== hdl/esc_div.sv =====
// ----------------------------------------------------------------------------
// esc_div
// Pipelined unsigned 32-bit restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module esc_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_v,
  input  logic [31:0]    num,
  input  logic [31:0]    den,
  input  esc_pkg::side_t in_side,
  output logic           out_v,
  output logic [31:0]    quot,
  output esc_pkg::side_t out_side
);

  // Index k holds the state after k quotient bits.
  logic [31:0]    rem_r  [1:esc_pkg::DIV_LAT];
  logic [31:0]    work_r [1:esc_pkg::DIV_LAT];
  logic [31:0]    den_r  [1:esc_pkg::DIV_LAT];
  esc_pkg::side_t side_r [1:esc_pkg::DIV_LAT];
  logic [esc_pkg::DIV_LAT:1] v_r;

  for (genvar k = 1; k <= esc_pkg::DIV_LAT; k++) begin : g_stage
    logic [31:0]    rem_in;
    logic [31:0]    work_in;
    logic [31:0]    den_in;
    esc_pkg::side_t side_in;
    logic           v_in;
    logic [32:0]    trial;
    logic [32:0]    diff;
    logic           fits;

    // The first stage starts from the request with an empty remainder.
    if (k == 1) begin : g_first
      assign rem_in  = '0;
      assign work_in = num;
      assign den_in  = den;
      assign side_in = in_side;
      assign v_in    = in_v;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign work_in = work_r[k-1];
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
      assign v_in    = v_r[k-1];
    end

    // Shift in the next numerator bit and try subtracting the divisor.
    always_comb begin
      trial = {rem_in, work_in[31]};
      diff  = trial - {1'b0, den_in};
      fits  = ~diff[32];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= fits ? diff[31:0] : trial[31:0];
        work_r[k] <= {work_in[30:0], fits};
        den_r[k]  <= den_in;
        side_r[k] <= side_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end
  end

  assign out_v    = v_r[esc_pkg::DIV_LAT];
  assign quot     = work_r[esc_pkg::DIV_LAT];
  assign out_side = side_r[esc_pkg::DIV_LAT];

endmodule

// ===== hdl/esc_back.sv =====
// ----------------------------------------------------------------------------
// esc_back
// Three-stage pressure finish: quadratic and linear correction of the
// quotient, then the divide-by-zero override.
// ----------------------------------------------------------------------------
module esc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_v,
  input  logic [31:0]    quot,
  input  esc_pkg::side_t in_side,
  input  esc_pkg::cal_t  cal,
  output logic           out_v,
  output logic [31:0]    pres,
  output esc_pkg::side_t out_side
);

  logic [31:0]    q1_r, sqq_r, e0_r;
  logic [31:0]    q2_r, c0_r, e_r;
  logic [31:0]    pres_r;
  esc_pkg::side_t s1_r, s2_r, s3_r;
  logic [2:0]     v_r;
  logic [31:0]    q_full;
  logic [31:0]    qs;

  // Double the quotient of a numerator whose top bit was set.
  assign q_full = in_side.mode ? (quot << 1) : quot;
  assign qs     = q_full >> 3;

  always_ff @(posedge clk) begin
    if (en) begin
      q1_r   <= q_full;
      sqq_r  <= qs * qs;
      e0_r   <= (q_full >> 2) * cal.p8;
      s1_r   <= in_side;
      q2_r   <= q1_r;
      c0_r   <= cal.p9 * (sqq_r >> 13);
      e_r    <= esc_pkg::asr(e0_r, 13);
      s2_r   <= s1_r;
      pres_r <= s2_r.dz ? 32'd0
              : q2_r + esc_pkg::asr(esc_pkg::asr(c0_r, 12) + e_r + cal.p7, 4);
      s3_r   <= s2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_v};
    end
  end

  assign out_v    = v_r[2];
  assign pres     = pres_r;
  assign out_side = s3_r;

endmodule

// ===== hdl/env_sensor_compensation.sv =====
// ----------------------------------------------------------------------------
// env_sensor_compensation
// Integer compensation of raw temperature, pressure and humidity samples.
// ----------------------------------------------------------------------------
// The block takes one raw sample request per clock while not stalled, and
// each request passes 14 arithmetic stages, a 32-stage pressure divider
// resolving one quotient bit per stage, 3 pressure finishing stages and the
// output register. Throughput is one request per cycle unless a stall on a
// valid output freezes the whole pipeline; the input stalls in the same cycle.
// Calibration registers are to be written only while no request is in flight.
module env_sensor_compensation (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [esc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [esc_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [19:0]                            in_raw_temperature,
  input  logic [19:0]                            in_raw_pressure,
  input  logic [15:0]                            in_raw_humidity,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [31:0]                     out_temperature_centi,
  output logic signed [31:0]                     out_fine_temperature,
  output logic [31:0]                            out_pressure_pa,
  output logic                                   out_pressure_div_zero,
  output logic [16:0]                            out_humidity_q10
);

  logic [47:0] temp_cal_r;
  logic [63:0] press_a_r;
  logic [63:0] press_b_r;
  logic [47:0] mixed_r;
  logic [39:0] humid_r;
  esc_pkg::cal_t cal;

  logic           en;
  logic           fr_v, dv_v, bk_v;
  logic [31:0]    fr_num, fr_den, dv_quot, bk_pres;
  esc_pkg::side_t fr_side, dv_side, bk_side;

  logic           out_v_r;
  logic [31:0]    out_temp_r, out_fine_r, out_pres_r;
  logic           out_dz_r;
  logic [16:0]    out_hum_r;

  // Calibration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r <= '0;
      press_a_r  <= '0;
      press_b_r  <= '0;
      mixed_r    <= '0;
      humid_r    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        esc_pkg::REG_TEMP:    temp_cal_r <= cfg_data[47:0];
        esc_pkg::REG_PRESS_A: press_a_r  <= cfg_data;
        esc_pkg::REG_PRESS_B: press_b_r  <= cfg_data;
        esc_pkg::REG_MIXED:   mixed_r    <= cfg_data[47:0];
        esc_pkg::REG_HUMID:   humid_r    <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  // Calibration word decode with sign or zero extension.
  always_comb begin
    cal.t1 = {16'b0, temp_cal_r[15:0]};
    cal.t2 = {{16{temp_cal_r[31]}}, temp_cal_r[31:16]};
    cal.t3 = {{16{temp_cal_r[47]}}, temp_cal_r[47:32]};
    cal.p1 = {16'b0, press_a_r[15:0]};
    cal.p2 = {{16{press_a_r[31]}}, press_a_r[31:16]};
    cal.p3 = {{16{press_a_r[47]}}, press_a_r[47:32]};
    cal.p4 = {{16{press_a_r[63]}}, press_a_r[63:48]};
    cal.p5 = {{16{press_b_r[15]}}, press_b_r[15:0]};
    cal.p6 = {{16{press_b_r[31]}}, press_b_r[31:16]};
    cal.p7 = {{16{press_b_r[47]}}, press_b_r[47:32]};
    cal.p8 = {{16{press_b_r[63]}}, press_b_r[63:48]};
    cal.p9 = {{16{mixed_r[15]}}, mixed_r[15:0]};
    cal.h1 = {24'b0, mixed_r[23:16]};
    cal.h2 = {{16{mixed_r[39]}}, mixed_r[39:24]};
    cal.h3 = {24'b0, mixed_r[47:40]};
    cal.h4 = {{16{humid_r[15]}}, humid_r[15:0]};
    cal.h5 = {{16{humid_r[31]}}, humid_r[31:16]};
    cal.h6 = {{24{humid_r[39]}}, humid_r[39:32]};
  end

  // The pipeline moves whenever the output register can take a new result.
  assign en       = !out_v_r || !out_stall;
  assign in_stall = !en;

  esc_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (in_valid),
    .adc_t (in_raw_temperature),
    .adc_p (in_raw_pressure),
    .adc_h (in_raw_humidity),
    .cal   (cal),
    .out_v (fr_v),
    .num   (fr_num),
    .den   (fr_den),
    .side  (fr_side)
  );

  esc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (fr_v),
    .num      (fr_num),
    .den      (fr_den),
    .in_side  (fr_side),
    .out_v    (dv_v),
    .quot     (dv_quot),
    .out_side (dv_side)
  );

  esc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (dv_v),
    .quot     (dv_quot),
    .in_side  (dv_side),
    .cal      (cal),
    .out_v    (bk_v),
    .pres     (bk_pres),
    .out_side (bk_side)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= bk_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_temp_r <= bk_side.temp;
      out_fine_r <= bk_side.fine;
      out_pres_r <= bk_pres;
      out_dz_r   <= bk_side.dz;
      out_hum_r  <= bk_side.hum;
    end
  end

  assign out_valid             = out_v_r;
  assign out_temperature_centi = $signed(out_temp_r);
  assign out_fine_temperature  = $signed(out_fine_r);
  assign out_pressure_pa       = out_pres_r;
  assign out_pressure_div_zero = out_dz_r;
  assign out_humidity_q10      = out_hum_r;

`ifndef NO_ASSERTIONS
  // A zero divisor always forces the pressure result to zero.
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pressure_div_zero |-> out_pressure_pa == 32'd0)
    else $error("pressure not zero with divide-by-zero flag");

  // Humidity stays within the clamped range.
  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_humidity_q10 <= 17'd102400)
    else $error("humidity above clamp limit");

  // The input is stalled exactly when a held result blocks the output.
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");
`endif

endmodule
